FILE: rtl/grs_pkg.sv
// Shared types, constants and helper functions of the gravity ray step block.
package grs_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_BASE_STEP      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRAVITY_GAIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NEAR_THRESHOLD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FAR_THRESHOLD  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPACE_BOUND    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BODIES_IN_USE  = 3'd5;

    localparam logic [31:0] RST_BASE_STEP      = 32'd19661;
    localparam logic [31:0] RST_GRAVITY_GAIN   = 32'd327680;
    localparam logic [31:0] RST_NEAR_THRESHOLD = 32'd65536000;
    localparam logic [31:0] RST_FAR_THRESHOLD  = 32'd327680000;
    localparam logic [30:0] RST_SPACE_BOUND    = 31'd19660800;
    localparam logic [2:0]  RST_BODIES_IN_USE  = 3'd3;

    localparam logic [1:0] ST_MOVED   = 2'd0;
    localparam logic [1:0] ST_CRASHED = 2'd1;
    localparam logic [1:0] ST_ESCAPED = 2'd2;

    // Datapath widths
    localparam int D_W    = 33;
    localparam int D2_W   = 50;
    localparam int R2_W   = 48;
    localparam int Q_W    = 48;
    localparam int ACC_W  = 50;
    localparam int DT_W   = 35;
    localparam int ROOT_W = 33;
    localparam int TERM_W = 47;

    // Shared multiplier: A times B, B taken 16 bits a cycle from the top
    localparam int MUL_A_W     = 50;
    localparam int MUL_CHUNK_W = 16;
    localparam int MUL_STEPS   = 3;
    localparam int MUL_B_W     = MUL_CHUNK_W * MUL_STEPS;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 50;
    localparam int SQ_X_W  = 64;
    localparam int SQ_R_W  = 32;

    localparam logic [TERM_W-1:0] CAP47 = '1;
    localparam logic [D2_W-1:0]   ONE_Q16 = D2_W'(65536);

    typedef enum logic [3:0] {
        OP_DIFF,
        OP_SQD,
        OP_SQR,
        OP_CHECK,
        OP_ROOT,
        OP_GM,
        OP_DIV1,
        OP_DIV2,
        OP_TERM,
        OP_DT,
        OP_VEL,
        OP_POS,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic       load;
        logic       latch;
        logic       go;
        logic       wb;
        op_t        op;
        logic [1:0] axis;
    } grs_cmd_t;

    typedef struct packed {
        logic unit_done;
        logic crash;
    } grs_stat_t;

    function automatic logic uses_unit(input op_t op);
        logic r;
        unique case (op)
            OP_SQD, OP_SQR, OP_ROOT, OP_GM, OP_DIV1, OP_DIV2,
            OP_TERM, OP_VEL, OP_POS: r = 1'b1;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    // min(product / 2^16, 2^47 - 1)
    function automatic logic [TERM_W-1:0] cap_q16(input logic [MUL_P_W-1:0] p);
        logic [MUL_P_W-17:0] sh;
        sh = p[MUL_P_W-1:16];
        return (sh > (MUL_P_W-16)'(CAP47)) ? CAP47 : sh[TERM_W-1:0];
    endfunction

    function automatic logic signed [TERM_W:0] signed_term(input logic neg,
                                                          input logic [TERM_W-1:0] m);
        logic signed [TERM_W:0] t;
        t = $signed({1'b0, m});
        return neg ? -t : t;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        logic [31:0] r;
        if (v[48:31] == {18{1'b0}} || v[48:31] == {18{1'b1}}) begin
            r = v[31:0];
        end else if (v[48]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: rtl/gravity_ray_integration_step_top.sv
// Top level of the gravity ray integration step block.
//
// A load transaction (command 0) writes one body entry in the cycle it is accepted and
// gives no result; a step transaction (command 1) keeps busy high while the block walks
// the bodies in use and then shows the updated ray on the result ports, with done high,
// for exactly one cycle. The receiver cannot stall, so results must be taken when done
// is high. The walk over the bodies ends early when the ray crashes; most of the step
// time goes to the shared bit-serial divider, which computes two quotients per body,
// and to the square root unit. Configuration writes are taken at any time but belong
// to idle periods.
module gravity_ray_integration_step_top import grs_pkg::*; #(
    parameter int MAX_BODIES = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  command,
    input  logic [1:0]            body_slot,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    pos_z,
    input  logic signed [31:0]    vel_x,
    input  logic signed [31:0]    vel_y,
    input  logic signed [31:0]    vel_z,
    input  logic [31:0]           body_mass,
    input  logic [31:0]           body_radius,
    output logic                  done,
    output logic signed [31:0]    new_x,
    output logic signed [31:0]    new_y,
    output logic signed [31:0]    new_z,
    output logic signed [31:0]    new_vx,
    output logic signed [31:0]    new_vy,
    output logic signed [31:0]    new_vz,
    output logic [1:0]            step_status
);

    localparam int CW = $clog2(MAX_BODIES + 1);

    grs_cmd_t      cmd;
    grs_stat_t     stat;
    logic [CW-1:0] body_idx;
    logic [CW-1:0] body_count;

    grs_ctrl #(
        .MAX_BODIES(MAX_BODIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .busy      (busy),
        .cmd       (cmd),
        .stat      (stat),
        .body_count(body_count),
        .body_idx  (body_idx)
    );

    grs_datapath #(
        .MAX_BODIES(MAX_BODIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .body_idx   (body_idx),
        .body_count (body_count),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .body_slot  (body_slot),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .body_mass  (body_mass),
        .body_radius(body_radius),
        .new_x      (new_x),
        .new_y      (new_y),
        .new_z      (new_z),
        .new_vx     (new_vx),
        .new_vy     (new_vy),
        .new_vz     (new_vz),
        .step_status(step_status),
        .done       (done)
    );

endmodule

FILE: rtl/grs_mul.sv
// Multi-cycle unsigned multiplier, one 16 bit slice of B per cycle.
module grs_mul import grs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_A_W-1:0]             a_reg;
    logic [MUL_B_W-1:0]             b_reg;
    logic [MUL_P_W-1:0]             prod_reg;
    logic [1:0]                     cnt_reg;
    logic                           run_reg;
    logic                           done_reg;
    logic [MUL_A_W+MUL_CHUNK_W-1:0] partial;

    assign partial = a_reg * b_reg[MUL_B_W-1 -: MUL_CHUNK_W];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'(MUL_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (go) begin
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= '0;
        end else if (run_reg) begin
            prod_reg <= {prod_reg[MUL_P_W-MUL_CHUNK_W-1:0], {MUL_CHUNK_W{1'b0}}}
                        + MUL_P_W'(partial);
            b_reg    <= {b_reg[MUL_B_W-MUL_CHUNK_W-1:0], {MUL_CHUNK_W{1'b0}}};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

FILE: rtl/grs_div.sv
// Restoring divider, one quotient bit per cycle.
module grs_div import grs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [DIV_N_W-1:0] num,
    input  logic [DIV_D_W-1:0] den,
    output logic               done,
    output logic [DIV_N_W-1:0] quo
);

    logic [DIV_N_W-1:0] q_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [5:0]         cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   rem_sh;
    logic               ge;
    logic [DIV_D_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, q_reg[DIV_N_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_N_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The remainder stays below the divisor, so its top bit can be dropped.
    always_ff @(posedge clk) begin
        if (go) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (run_reg) begin
            q_reg   <= {q_reg[DIV_N_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

FILE: rtl/grs_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module grs_sqrt import grs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [SQ_X_W-1:0] x,
    output logic              done,
    output logic [SQ_R_W-1:0] root
);

    logic [SQ_X_W-1:0] x_reg;
    logic [SQ_R_W+1:0] rem_reg;
    logic [SQ_R_W-1:0] root_reg;
    logic [4:0]        cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [SQ_R_W+3:0] rem_sh;
    logic [SQ_R_W+1:0] trial;
    logic              ge;
    logic [SQ_R_W+3:0] rem_sub;

    assign rem_sh  = {rem_reg, x_reg[SQ_X_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign ge      = rem_sh >= (SQ_R_W+4)'(trial);
    assign rem_sub = rem_sh - (SQ_R_W+4)'(trial);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQ_R_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The partial remainder never exceeds twice the partial root.
    always_ff @(posedge clk) begin
        if (go) begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            x_reg    <= {x_reg[SQ_X_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[SQ_R_W+1:0] : rem_sh[SQ_R_W+1:0];
            root_reg <= {root_reg[SQ_R_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: rtl/grs_ctrl.sv
// Controller: sequences the per-body and update operations of one ray step.
module grs_ctrl import grs_pkg::*; #(
    parameter int MAX_BODIES = 4,
    parameter int CW = $clog2(MAX_BODIES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          command,
    output logic          busy,
    output grs_cmd_t      cmd,
    input  grs_stat_t     stat,
    input  logic [CW-1:0] body_count,
    output logic [CW-1:0] body_idx
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_WB
    } state_t;

    state_t        state_reg;
    op_t           op_reg;
    op_t           op_next;
    logic [1:0]    axis_reg;
    logic [1:0]    axis_next;
    logic [CW-1:0] body_reg;
    logic [CW-1:0] body_next;
    logic [CW-1:0] body_inc;

    assign body_inc = CW'(body_reg + 1'b1);

    always_comb begin
        op_next   = op_reg;
        axis_next = axis_reg;
        body_next = body_reg;
        unique case (op_reg)
            OP_DIFF: begin
                op_next   = OP_SQD;
                axis_next = 2'd0;
            end
            OP_SQD: begin
                if (axis_reg == 2'd2) begin
                    op_next = OP_SQR;
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            OP_SQR:   op_next = OP_CHECK;
            OP_CHECK: op_next = stat.crash ? OP_FINISH : OP_ROOT;
            OP_ROOT:  op_next = OP_GM;
            OP_GM:    op_next = OP_DIV1;
            OP_DIV1:  op_next = OP_DIV2;
            OP_DIV2: begin
                op_next   = OP_TERM;
                axis_next = 2'd0;
            end
            OP_TERM: begin
                if (axis_reg != 2'd2) begin
                    axis_next = axis_reg + 2'd1;
                end else if (body_inc < body_count) begin
                    op_next   = OP_DIFF;
                    body_next = body_inc;
                end else begin
                    op_next = OP_DT;
                end
            end
            OP_DT: begin
                op_next   = OP_VEL;
                axis_next = 2'd0;
            end
            OP_VEL: op_next = OP_POS;
            OP_POS: begin
                if (axis_reg == 2'd2) begin
                    op_next = OP_FINISH;
                end else begin
                    op_next   = OP_VEL;
                    axis_next = axis_reg + 2'd1;
                end
            end
            default: op_next = OP_FINISH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_DIFF;
            axis_reg  <= '0;
            body_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start && command) begin
                        op_reg    <= (body_count == '0) ? OP_DT : OP_DIFF;
                        axis_reg  <= '0;
                        body_reg  <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (uses_unit(op_reg)) begin
                        state_reg <= S_WAIT;
                    end else if (op_reg == OP_FINISH) begin
                        state_reg <= S_IDLE;
                    end else begin
                        op_reg   <= op_next;
                        axis_reg <= axis_next;
                        body_reg <= body_next;
                    end
                end
                S_WAIT: begin
                    if (stat.unit_done) begin
                        state_reg <= S_WB;
                    end
                end
                S_WB: begin
                    op_reg    <= op_next;
                    axis_reg  <= axis_next;
                    body_reg  <= body_next;
                    state_reg <= S_ISSUE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cmd.load  = start && !busy && !command;
    assign cmd.latch = start && !busy && command;
    assign cmd.go    = (state_reg == S_ISSUE);
    assign cmd.wb    = (state_reg == S_WB);
    assign cmd.op    = op_reg;
    assign cmd.axis  = axis_reg;
    assign body_idx  = body_reg;

`ifndef SYNTHESIS
    a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE && op_reg == OP_FINISH) |=> !busy)
        else $error("controller still busy after the result");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.unit_done |-> state_reg == S_WAIT)
        else $error("arithmetic unit finished while not awaited");

    a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE && op_reg == OP_DIFF) |-> body_reg < body_count)
        else $error("body index beyond bodies in use");
`endif

endmodule

FILE: rtl/grs_datapath.sv
// Datapath: configuration, body table, ray state and the shared arithmetic units.
module grs_datapath import grs_pkg::*; #(
    parameter int MAX_BODIES = 4,
    parameter int CW = $clog2(MAX_BODIES + 1),
    parameter int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  grs_cmd_t              cmd,
    output grs_stat_t             stat,
    input  logic [CW-1:0]         body_idx,
    output logic [CW-1:0]         body_count,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]            body_slot,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    pos_z,
    input  logic signed [31:0]    vel_x,
    input  logic signed [31:0]    vel_y,
    input  logic signed [31:0]    vel_z,
    input  logic [31:0]           body_mass,
    input  logic [31:0]           body_radius,
    output logic signed [31:0]    new_x,
    output logic signed [31:0]    new_y,
    output logic signed [31:0]    new_z,
    output logic signed [31:0]    new_vx,
    output logic signed [31:0]    new_vy,
    output logic signed [31:0]    new_vz,
    output logic [1:0]            step_status,
    output logic                  done
);

    logic [31:0] base_step_reg, gravity_gain_reg, near_threshold_reg, far_threshold_reg;
    logic [30:0] space_bound_reg;
    logic [2:0]  bodies_in_use_reg;

    logic [31:0] body_px [MAX_BODIES];
    logic [31:0] body_py [MAX_BODIES];
    logic [31:0] body_pz [MAX_BODIES];
    logic [31:0] body_m  [MAX_BODIES];
    logic [31:0] body_r  [MAX_BODIES];

    logic signed [31:0]      p_reg   [3];
    logic signed [31:0]      v_reg   [3];
    logic signed [D_W-1:0]   d_reg   [3];
    logic signed [ACC_W-1:0] acc_reg [3];
    logic [D2_W-1:0]   d2_reg, least_reg, s_reg;
    logic [R2_W-1:0]   r2_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [Q_W-1:0]    gm_reg, k1_reg, k_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [31:0]       br_reg;
    logic [31:0]       bm_reg;
    logic              crash_reg;
    logic              done_reg;

    logic [IW-1:0]      rd_idx;
    logic [IW-1:0]      wr_idx;
    logic               slot_ok;
    logic [D_W-1:0]     d_mag;
    logic [ACC_W-1:0]   acc_mag;
    logic [31:0]        v_mag;
    logic               mul_go, div_go, sqrt_go;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic [DIV_N_W-1:0] div_num, quo;
    logic [DIV_D_W-1:0] div_den;
    logic [SQ_R_W-1:0]  sq_root;
    logic               mul_done, div_done, sqrt_done;
    logic [TERM_W-1:0]  capped;
    logic [1:0]         shamt;
    logic               out_of_bounds;
    logic [31:0]        p_mag [3];

    assign rd_idx  = body_idx[IW-1:0];
    assign wr_idx  = IW'(body_slot);
    assign slot_ok = int'(body_slot) < MAX_BODIES;

    assign body_count = (int'(bodies_in_use_reg) > MAX_BODIES) ? CW'(MAX_BODIES)
                                                                : CW'(bodies_in_use_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            base_step_reg      <= RST_BASE_STEP;
            gravity_gain_reg   <= RST_GRAVITY_GAIN;
            near_threshold_reg <= RST_NEAR_THRESHOLD;
            far_threshold_reg  <= RST_FAR_THRESHOLD;
            space_bound_reg    <= RST_SPACE_BOUND;
            bodies_in_use_reg  <= RST_BODIES_IN_USE;
            crash_reg          <= 1'b0;
            done_reg           <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_BASE_STEP:      base_step_reg      <= cfg_wdata;
                    REG_GRAVITY_GAIN:   gravity_gain_reg   <= cfg_wdata;
                    REG_NEAR_THRESHOLD: near_threshold_reg <= cfg_wdata;
                    REG_FAR_THRESHOLD:  far_threshold_reg  <= cfg_wdata;
                    REG_SPACE_BOUND:    space_bound_reg    <= cfg_wdata[30:0];
                    REG_BODIES_IN_USE:  bodies_in_use_reg  <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (cmd.latch) begin
                crash_reg <= 1'b0;
            end else if (cmd.go && cmd.op == OP_CHECK) begin
                crash_reg <= stat.crash;
            end
            done_reg <= cmd.go && cmd.op == OP_FINISH;
        end
    end

    assign d_mag   = d_reg[cmd.axis][D_W-1] ? D_W'(-d_reg[cmd.axis]) : D_W'(d_reg[cmd.axis]);
    assign acc_mag = acc_reg[cmd.axis][ACC_W-1] ? ACC_W'(-acc_reg[cmd.axis])
                                                : ACC_W'(acc_reg[cmd.axis]);
    assign v_mag   = v_reg[cmd.axis][31] ? 32'(-v_reg[cmd.axis]) : 32'(v_reg[cmd.axis]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQD: begin
                mul_a = MUL_A_W'(d_mag);
                mul_b = MUL_B_W'(d_mag);
            end
            OP_SQR: begin
                mul_a = MUL_A_W'(br_reg);
                mul_b = MUL_B_W'(br_reg);
            end
            OP_GM: begin
                mul_a = MUL_A_W'(gravity_gain_reg);
                mul_b = MUL_B_W'(bm_reg);
            end
            OP_TERM: begin
                mul_a = MUL_A_W'(k_reg);
                mul_b = MUL_B_W'(d_mag);
            end
            OP_VEL: begin
                mul_a = acc_mag;
                mul_b = MUL_B_W'(dt_reg);
            end
            OP_POS: begin
                mul_a = MUL_A_W'(v_mag);
                mul_b = MUL_B_W'(dt_reg);
            end
            default: ;
        endcase
    end

    assign mul_go  = cmd.go && (cmd.op == OP_SQD || cmd.op == OP_SQR || cmd.op == OP_GM
                                || cmd.op == OP_TERM || cmd.op == OP_VEL || cmd.op == OP_POS);
    assign div_go  = cmd.go && (cmd.op == OP_DIV1 || cmd.op == OP_DIV2);
    assign sqrt_go = cmd.go && cmd.op == OP_ROOT;

    assign div_num = (cmd.op == OP_DIV1) ? {gm_reg, 16'b0} : {k1_reg, 16'b0};
    assign div_den = (cmd.op == OP_DIV1) ? s_reg : DIV_D_W'(root_reg);

    grs_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mul_go),
        .a    (mul_a),
        .b    (mul_b),
        .done (mul_done),
        .prod (prod)
    );

    grs_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (quo)
    );

    grs_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (sqrt_go),
        .x    ({s_reg, 14'b0}),
        .done (sqrt_done),
        .root (sq_root)
    );

    assign stat.unit_done = mul_done || div_done || sqrt_done;
    assign stat.crash     = D2_W'(r2_reg) > d2_reg;

    assign capped = cap_q16(prod);
    assign shamt  = {least_reg > D2_W'(far_threshold_reg), least_reg > D2_W'(near_threshold_reg)};

    always_comb begin
        out_of_bounds = 1'b0;
        for (int a = 0; a < 3; a++) begin
            p_mag[a] = p_reg[a][31] ? 32'(-p_reg[a]) : 32'(p_reg[a]);
            if (p_mag[a] > {1'b0, space_bound_reg}) begin
                out_of_bounds = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load && slot_ok) begin
            body_px[wr_idx] <= pos_x;
            body_py[wr_idx] <= pos_y;
            body_pz[wr_idx] <= pos_z;
            body_m[wr_idx]  <= body_mass;
            body_r[wr_idx]  <= body_radius;
        end
        if (cmd.latch) begin
            p_reg[0]  <= pos_x;
            p_reg[1]  <= pos_y;
            p_reg[2]  <= pos_z;
            v_reg[0]  <= vel_x;
            v_reg[1]  <= vel_y;
            v_reg[2]  <= vel_z;
            acc_reg   <= '{default: '0};
            least_reg <= '1;
        end
        if (cmd.go) begin
            unique case (cmd.op)
                OP_DIFF: begin
                    d_reg[0] <= $signed({body_px[rd_idx][31], body_px[rd_idx]})
                                - $signed({p_reg[0][31], p_reg[0]});
                    d_reg[1] <= $signed({body_py[rd_idx][31], body_py[rd_idx]})
                                - $signed({p_reg[1][31], p_reg[1]});
                    d_reg[2] <= $signed({body_pz[rd_idx][31], body_pz[rd_idx]})
                                - $signed({p_reg[2][31], p_reg[2]});
                    br_reg   <= body_r[rd_idx];
                    bm_reg   <= body_m[rd_idx];
                    d2_reg   <= '0;
                end
                OP_CHECK: begin
                    if (!stat.crash && d2_reg < least_reg) begin
                        least_reg <= d2_reg;
                    end
                    s_reg <= (d2_reg > ONE_Q16) ? d2_reg : ONE_Q16;
                end
                OP_DT: dt_reg <= DT_W'(base_step_reg) << (shamt[0] + 2 * shamt[1]);
                OP_FINISH: begin
                    new_x  <= p_reg[0];
                    new_y  <= p_reg[1];
                    new_z  <= p_reg[2];
                    new_vx <= v_reg[0];
                    new_vy <= v_reg[1];
                    new_vz <= v_reg[2];
                    if (crash_reg) begin
                        step_status <= ST_CRASHED;
                    end else if (out_of_bounds) begin
                        step_status <= ST_ESCAPED;
                    end else begin
                        step_status <= ST_MOVED;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.wb) begin
            unique case (cmd.op)
                OP_SQD:  d2_reg   <= d2_reg + prod[D2_W+15:16];
                OP_SQR:  r2_reg   <= prod[R2_W+15:16];
                OP_ROOT: root_reg <= {sq_root, 1'b0};
                OP_GM:   gm_reg   <= prod[Q_W+15:16];
                OP_DIV1: k1_reg   <= quo[Q_W-1:0];
                OP_DIV2: k_reg    <= quo[Q_W-1:0];
                OP_TERM: acc_reg[cmd.axis] <= acc_reg[cmd.axis]
                             + ACC_W'(signed_term(d_reg[cmd.axis][D_W-1], capped));
                OP_VEL:  v_reg[cmd.axis] <= sat32(49'(v_reg[cmd.axis])
                             + 49'(signed_term(acc_reg[cmd.axis][ACC_W-1], capped)));
                OP_POS:  p_reg[cmd.axis] <= sat32(49'(p_reg[cmd.axis])
                             + 49'(signed_term(v_reg[cmd.axis][31], capped)));
                default: ;
            endcase
        end
    end

    assign done = done_reg;

endmodule
